/* design/tsl_pkg.sv */
// Shared types, constants and helpers of the tabular Sarsa(lambda) learner.
package tsl_pkg;

  // Default table geometry
  localparam int unsigned NUM_STATES_DEF  = 256;
  localparam int unsigned NUM_ACTIONS_DEF = 8;

  // Field widths
  localparam int unsigned Q_W   = 24;  // value and TD error, 12 fraction bits
  localparam int unsigned T_W   = 16;  // trace, 10 fraction bits
  localparam int unsigned P_W   = 17;  // pursuit probability, 16 fraction bits
  localparam int unsigned CFG_W = 17;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned AD_W  = 42;  // alpha * delta
  localparam int unsigned PR_W  = 59;  // alpha * delta * trace

  // Trace constants
  localparam logic [T_W-1:0] TRACE_ONE  = 16'd1024;
  localparam logic [T_W-1:0] TRACE_KEEP = 16'd11;

  // Register clamps
  localparam logic [CFG_W-1:0] FRAC_ONE  = 17'd65536;
  localparam logic [15:0]      RATE_MAX  = 16'd64880;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_LEARN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_DISC    = 3'd1;
  localparam logic [IDX_W-1:0] REG_DECAY   = 3'd2;
  localparam logic [IDX_W-1:0] REG_EXPLORE = 3'd3;
  localparam logic [IDX_W-1:0] REG_PURSUIT = 3'd4;
  localparam logic [IDX_W-1:0] REG_QLEARN  = 3'd5;
  localparam logic [IDX_W-1:0] REG_SELECT  = 3'd6;
  localparam logic [IDX_W-1:0] REG_REPLACE = 3'd7;

  // Selection modes
  localparam logic [1:0] SEL_EPS     = 2'd0;
  localparam logic [1:0] SEL_PURSUIT = 2'd1;
  localparam logic [1:0] SEL_FORCED  = 2'd2;

  // Commands
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Sweep control handed to every lane
  typedef struct packed {
    logic signed [AD_W-1:0] ad;
    logic [T_W-1:0]         gl;
    logic                   keep;
  } lane_ctl_t;

  // Saturate a wide signed sum to the 24-bit value range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [39:0] x);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd8388607;
    lo = -40'sd8388608;
    if (x > hi) begin
      sat_q = 24'sh7FFFFF;
    end else if (x < lo) begin
      sat_q = -24'sh800000;
    end else begin
      sat_q = x[Q_W-1:0];
    end
  endfunction

endpackage

/* design/tsl_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
module tsl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* design/tsl_lane.sv */
// One action lane of the table sweep: value update and trace decay.
module tsl_lane (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [tsl_pkg::Q_W-1:0] value_i,
  input  logic [tsl_pkg::T_W-1:0]   trace_i,
  input  tsl_pkg::lane_ctl_t        ctl_i,
  output logic signed [tsl_pkg::Q_W-1:0] value_o,
  output logic [tsl_pkg::T_W-1:0]   trace_o
);
  import tsl_pkg::*;

  logic signed [PR_W-1:0] prod_q;
  logic signed [Q_W-1:0]  val_q;
  logic [T_W-1:0]         nt_q;
  logic                   elig_q;
  logic                   elig;
  logic [31:0]            tdec;

  assign elig = (trace_i >= TRACE_KEEP);
  assign tdec = 32'(trace_i) * 32'(ctl_i.gl);

  // Stage one: products of the eligible entry
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ctl_i.ad * $signed({1'b0, trace_i});
      val_q  <= value_i;
      elig_q <= elig;
      nt_q   <= (elig && ctl_i.keep) ? tdec[31:16] : '0;
    end
  end

  // Stage two: floor shift, accumulate, saturate
  assign value_o = elig_q ? sat_q(40'(val_q) + 40'(prod_q >>> 26)) : val_q;
  assign trace_o = nt_q;

endmodule

/* design/tabular_sarsa_lambda_learner_unit.sv */
// Top level of the tabular Sarsa(lambda) / Q(lambda) learner.
// Usage: pulse start with the item fields while busy is low; the item is taken
// at that edge. The result (action_o, td_error_o) is shown for one cycle with
// done_o high and must be taken then; the receiver cannot stall the block.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
// Value and pursuit tables share one row-wide RAM and the trace table has a
// second one; one row per state, all actions of a row side by side.
// A learning step skips the draw pass outside pursuit mode and runs no table
// sweep on the first step; the sweep reads and writes one state row per cycle
// and sets the rate. End of episode clears the trace table. An out-of-range
// state answers in the cycle after start and busy stays low.
// After reset the block runs a clearing pass over both memories with busy
// high; configuration writes are taken during it.
module tabular_sarsa_lambda_learner_unit #(
  parameter int unsigned NUM_STATES  = tsl_pkg::NUM_STATES_DEF,
  parameter int unsigned NUM_ACTIONS = tsl_pkg::NUM_ACTIONS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd_i,
  input  logic [7:0]                   state_index_i,
  input  logic signed [15:0]           reward_i,
  input  logic [2:0]                   forced_action_i,
  input  logic [15:0]                  rand_fraction_i,
  input  logic [2:0]                   rand_action_i,
  input  logic                         cfg_we_i,
  input  logic [tsl_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [tsl_pkg::CFG_W-1:0]    cfg_data_i,
  output logic                         done_o,
  output logic [2:0]                   action_o,
  output logic signed [tsl_pkg::Q_W-1:0] td_error_o
);
  import tsl_pkg::*;

  localparam int unsigned NS   = NUM_STATES;
  localparam int unsigned NA   = NUM_ACTIONS;
  localparam int unsigned SW   = $clog2(NS);
  localparam int unsigned AW   = $clog2(NA);
  localparam int unsigned SUMW = P_W + AW;
  localparam int unsigned VQW  = NA * Q_W;  // value part of a shared row
  localparam int unsigned VPW  = NA * P_W;  // pursuit part of a shared row
  localparam logic [P_W-1:0] PROB_INIT = P_W'(65536 / NA);

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_CLR    = 4'd2;
  localparam logic [3:0] ST_LOAD   = 4'd3;
  localparam logic [3:0] ST_LOAD2  = 4'd4;
  localparam logic [3:0] ST_GREEDY = 4'd5;
  localparam logic [3:0] ST_PURSUE = 4'd6;
  localparam logic [3:0] ST_PWRITE = 4'd7;
  localparam logic [3:0] ST_DRAW   = 4'd8;
  localparam logic [3:0] ST_TD     = 4'd9;
  localparam logic [3:0] ST_DELTA  = 4'd10;
  localparam logic [3:0] ST_PREP   = 4'd11;
  localparam logic [3:0] ST_SWEEP  = 4'd12;
  localparam logic [3:0] ST_FINISH = 4'd13;

  // Configuration registers
  logic [CFG_W-1:0] learn_rate_q, explore_rate_q, pursuit_step_q;
  logic [15:0]      discount_q, trace_decay_q;
  logic             use_q_q, replace_q;
  logic [1:0]       sel_mode_q;

  // Control and item registers
  logic [3:0]        st_q;
  logic [SW:0]       cnt_q;
  logic [AW:0]       jc_q;
  logic [SW-1:0]     s_q;
  logic signed [15:0] r_q;
  logic [15:0]       rf_q;
  logic [2:0]        ra_q, fa_q;
  logic [7:0]        prev_state_q;
  logic [2:0]        prev_action_q;
  logic              prev_valid_q;
  logic signed [Q_W-1:0] last_td_q;
  logic              done_q;
  logic [2:0]        action_q;
  logic signed [Q_W-1:0] td_q;

  // Row and step datapath registers
  logic signed [Q_W-1:0] vrow_q [NA];
  logic [P_W-1:0]        prow_q [NA];
  logic [T_W-1:0]        ptrow_q [NA];
  logic signed [Q_W-1:0] pv_q, max_q;
  logic [AW-1:0]         g_q, a_q, draw_a_q;
  logic [SUMW-1:0]       sum_q, x_q, run_q;
  logic                  found_q, keep_q;
  logic signed [40:0]    eqg_q;
  lane_ctl_t             ctl_q;

  // Sweep pipeline
  logic          v1_q, v2_q;
  logic [SW-1:0] a1_q, a2_q;
  logic          sweep_rd;
  logic [VPW-1:0] sw_p_q;  // pursuit part carried past the lanes

  // RAM ports
  logic                vram_we, tram_we;
  logic [SW-1:0]       vram_wa, tram_wa, vram_ra, tram_ra;
  logic [VPW+VQW-1:0]  vram_wd, vram_rd;
  logic [VQW-1:0]      sw_v;
  logic [NA*T_W-1:0]   tram_wd, tram_rd, sw_t;

  // Combinational helpers
  logic [AW-1:0]    j;
  logic             j_last;
  logic             in_range;
  logic [P_W-1:0]   p_cur, p_op, p_new;
  logic [33:0]      p_mul;
  logic [SUMW-1:0]  run_new;
  logic [SUMW+15:0] x_mul;
  logic [6:0]       ra_m;
  logic [AW-1:0]    ra_mod, a_sel, tgt;
  logic [AW-1:0]    pa;
  logic [T_W-1:0]   t_bump;
  logic [16:0]      t_sum;
  logic [31:0]      gl_mul;
  logic signed [Q_W-1:0] delta_sat;

  assign j        = jc_q[AW-1:0];
  assign j_last   = (jc_q == (AW+1)'(NA - 1));
  assign in_range = (32'(state_index_i) < NS);
  assign sweep_rd = (st_q == ST_SWEEP) && (cnt_q < (SW+1)'(NS));
  assign pa       = AW'(prev_action_q);
  assign busy     = (st_q != ST_IDLE);

  // Pursuit update of one lane
  always_comb begin
    p_cur = prow_q[j];
    p_op  = (j == g_q) ? (FRAC_ONE - p_cur) : p_cur;
    p_mul = 34'(pursuit_step_q) * 34'(p_op);
    p_new = (j == g_q) ? (p_cur + P_W'(p_mul[33:16])) : (p_cur - P_W'(p_mul[33:16]));
  end

  assign run_new = run_q + SUMW'(prow_q[j]);
  assign x_mul   = (SUMW+16)'(rf_q) * (SUMW+16)'(sum_q);

  // Random action reduced to the action range
  always_comb begin
    ra_m = 7'(ra_q);
    for (int k = 0; k < 4; k++) begin
      if (ra_m >= 7'(NA)) begin
        ra_m = ra_m - 7'(NA);
      end
    end
    ra_mod = AW'(ra_m);
  end

  // Action selection
  always_comb begin
    case (sel_mode_q)
      SEL_FORCED:  a_sel = (32'(fa_q) >= NA) ? ra_mod : AW'(fa_q);
      SEL_PURSUIT: a_sel = draw_a_q;
      default:     a_sel = ({1'b0, rf_q} < explore_rate_q) ? ra_mod : g_q;
    endcase
    tgt = use_q_q ? g_q : a_sel;
  end

  // TD error and trace bump of the previous pair
  assign delta_sat = sat_q(40'(r_q) + 40'(eqg_q >>> 16) - 40'(pv_q));
  assign t_sum     = 17'(ptrow_q[pa]) + 17'(TRACE_ONE);
  assign t_bump    = replace_q ? TRACE_ONE : (t_sum[16] ? 16'hFFFF : t_sum[15:0]);
  assign gl_mul    = 32'(discount_q) * 32'(trace_decay_q);

  // RAM port steering
  always_comb begin
    vram_we = 1'b0;
    tram_we = 1'b0;
    vram_wa = a2_q;
    tram_wa = a2_q;
    vram_wd = {sw_p_q, sw_v};
    tram_wd = sw_t;
    vram_ra = SW'(state_index_i);
    tram_ra = SW'(prev_state_q);
    unique case (st_q)
      ST_INIT: begin
        vram_we = 1'b1;
        tram_we = 1'b1;
        vram_wa = cnt_q[SW-1:0];
        tram_wa = cnt_q[SW-1:0];
        vram_wd = '0;
        tram_wd = '0;
        for (int k = 0; k < NA; k++) begin
          vram_wd[VQW + k*P_W +: P_W] = PROB_INIT;
        end
      end
      ST_CLR: begin
        tram_we = 1'b1;
        tram_wa = cnt_q[SW-1:0];
        tram_wd = '0;
      end
      ST_LOAD: begin
        vram_ra = SW'(prev_state_q);
      end
      ST_PWRITE: begin
        vram_we = 1'b1;
        vram_wa = s_q;
        for (int k = 0; k < NA; k++) begin
          vram_wd[k*Q_W +: Q_W]         = vrow_q[k];
          vram_wd[VQW + k*P_W +: P_W]   = prow_q[k];
        end
      end
      ST_PREP: begin
        tram_we = 1'b1;
        tram_wa = SW'(prev_state_q);
        for (int k = 0; k < NA; k++) begin
          tram_wd[k*T_W +: T_W] = (AW'(k) == pa) ? t_bump : ptrow_q[k];
        end
      end
      ST_SWEEP: begin
        vram_we = v2_q;
        tram_we = v2_q;
        vram_ra = cnt_q[SW-1:0];
        tram_ra = cnt_q[SW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Table memories: value and pursuit rows together, traces apart
  tsl_ram #(.WIDTH(VPW+VQW), .DEPTH(NS)) u_vram (
    .clk_i, .we_i(vram_we), .waddr_i(vram_wa), .wdata_i(vram_wd),
    .raddr_i(vram_ra), .rdata_o(vram_rd)
  );
  tsl_ram #(.WIDTH(NA*T_W), .DEPTH(NS)) u_tram (
    .clk_i, .we_i(tram_we), .waddr_i(tram_wa), .wdata_i(tram_wd),
    .raddr_i(tram_ra), .rdata_o(tram_rd)
  );

  // Sweep lanes, one per action
  for (genvar k = 0; k < NA; k++) begin : g_lane
    tsl_lane u_lane (
      .clk_i,
      .en_i   (v1_q),
      .value_i(vram_rd[k*Q_W +: Q_W]),
      .trace_i(tram_rd[k*T_W +: T_W]),
      .ctl_i  (ctl_q),
      .value_o(sw_v[k*Q_W +: Q_W]),
      .trace_o(sw_t[k*T_W +: T_W])
    );
  end

  // Pursuit part of a swept row, held alongside the lane stage
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      sw_p_q <= vram_rd[VQW +: VPW];
    end
  end

  // Sequencer, configuration and step registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q           <= ST_INIT;
      cnt_q          <= '0;
      jc_q           <= '0;
      done_q         <= 1'b0;
      action_q       <= '0;
      td_q           <= '0;
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      a1_q           <= '0;
      a2_q           <= '0;
      prev_state_q   <= '0;
      prev_action_q  <= '0;
      prev_valid_q   <= 1'b0;
      last_td_q      <= '0;
      learn_rate_q   <= 17'd6554;
      discount_q     <= 16'd58982;
      trace_decay_q  <= 16'd45875;
      explore_rate_q <= 17'd6554;
      pursuit_step_q <= 17'd655;
      use_q_q        <= 1'b0;
      sel_mode_q     <= SEL_EPS;
      replace_q      <= 1'b0;
    end else begin
      done_q <= 1'b0;
      v1_q   <= sweep_rd;
      a1_q   <= cnt_q[SW-1:0];
      v2_q   <= v1_q;
      a2_q   <= a1_q;

      // Register writes, clamped on the way in
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_LEARN:   learn_rate_q <= (cfg_data_i > FRAC_ONE) ? FRAC_ONE : cfg_data_i;
          REG_DISC:    discount_q <= (cfg_data_i[15:0] > RATE_MAX) ? RATE_MAX
                                                                   : cfg_data_i[15:0];
          REG_DECAY:   trace_decay_q <= (cfg_data_i[15:0] > RATE_MAX) ? RATE_MAX
                                                                      : cfg_data_i[15:0];
          REG_EXPLORE: explore_rate_q <= (cfg_data_i > FRAC_ONE) ? FRAC_ONE : cfg_data_i;
          REG_PURSUIT: pursuit_step_q <= (cfg_data_i > FRAC_ONE) ? FRAC_ONE : cfg_data_i;
          REG_QLEARN:  use_q_q <= cfg_data_i[0];
          REG_SELECT:  sel_mode_q <= cfg_data_i[1:0];
          REG_REPLACE: replace_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end

      unique case (st_q)
        ST_INIT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == (SW+1)'(NS - 1)) begin
            st_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            s_q   <= SW'(state_index_i);
            r_q   <= reward_i;
            rf_q  <= rand_fraction_i;
            ra_q  <= rand_action_i;
            fa_q  <= forced_action_i;
            cnt_q <= '0;
            if (cmd_i == CMD_END) begin
              st_q <= ST_CLR;
            end else if (!in_range) begin
              done_q   <= 1'b1;
              action_q <= '0;
              td_q     <= last_td_q;
            end else begin
              st_q <= ST_LOAD;
            end
          end
        end
        ST_CLR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == (SW+1)'(NS - 1)) begin
            done_q   <= 1'b1;
            action_q <= '0;
            td_q     <= last_td_q;
            st_q     <= ST_IDLE;
          end
        end
        ST_LOAD: begin
          for (int k = 0; k < NA; k++) begin
            vrow_q[k] <= vram_rd[k*Q_W +: Q_W];
            prow_q[k] <= vram_rd[VQW + k*P_W +: P_W];
          end
          st_q <= ST_LOAD2;
        end
        ST_LOAD2: begin
          pv_q <= vram_rd[32'(pa)*Q_W +: Q_W];
          for (int k = 0; k < NA; k++) begin
            ptrow_q[k] <= tram_rd[k*T_W +: T_W];
          end
          jc_q <= '0;
          st_q <= ST_GREEDY;
        end
        ST_GREEDY: begin
          if (jc_q == '0 || max_q < vrow_q[j]) begin
            max_q <= vrow_q[j];
            g_q   <= j;
          end
          if (j_last) begin
            jc_q  <= '0;
            sum_q <= '0;
            st_q  <= ST_PURSUE;
          end else begin
            jc_q <= jc_q + 1'b1;
          end
        end
        ST_PURSUE: begin
          prow_q[j] <= p_new;
          sum_q     <= sum_q + SUMW'(p_new);
          if (j_last) begin
            jc_q <= '0;
            st_q <= ST_PWRITE;
          end else begin
            jc_q <= jc_q + 1'b1;
          end
        end
        ST_PWRITE: begin
          x_q      <= x_mul[SUMW+15:16];
          run_q    <= '0;
          found_q  <= 1'b0;
          draw_a_q <= '0;
          st_q     <= (sel_mode_q == SEL_PURSUIT) ? ST_DRAW : ST_TD;
        end
        ST_DRAW: begin
          run_q <= run_new;
          if (!found_q && x_q <= run_new) begin
            found_q  <= 1'b1;
            draw_a_q <= j;
          end
          if (j_last) begin
            jc_q <= '0;
            st_q <= ST_TD;
          end else begin
            jc_q <= jc_q + 1'b1;
          end
        end
        ST_TD: begin
          a_q    <= a_sel;
          keep_q <= (tgt == a_sel);
          eqg_q  <= $signed({1'b0, discount_q}) * vrow_q[tgt];
          st_q   <= prev_valid_q ? ST_DELTA : ST_FINISH;
        end
        ST_DELTA: begin
          last_td_q <= delta_sat;
          st_q      <= ST_PREP;
        end
        ST_PREP: begin
          ctl_q.ad   <= $signed({1'b0, learn_rate_q}) * last_td_q;
          ctl_q.gl   <= gl_mul[31:16];
          ctl_q.keep <= keep_q;
          cnt_q      <= '0;
          st_q       <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (sweep_rd) begin
            cnt_q <= cnt_q + 1'b1;
          end else if (!v1_q && !v2_q) begin
            st_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          prev_state_q  <= 8'(s_q);
          prev_action_q <= 3'(a_q);
          prev_valid_q  <= 1'b1;
          done_q        <= 1'b1;
          action_q      <= 3'(a_q);
          td_q          <= last_td_q;
          st_q          <= ST_IDLE;
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o     = done_q;
  assign action_o   = action_q;
  assign td_error_o = td_q;

  // The shared value memory is only written by clearing, pursuit write-back and sweep
  a_vram_wr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vram_we |-> (st_q == ST_INIT || st_q == ST_PWRITE || st_q == ST_SWEEP))
    else $error("value table written outside clearing pass, pursuit write or sweep");

  // A sweep write-back never lands on the row being read
  a_sweep_rw : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && sweep_rd) |-> (a2_q != cnt_q[SW-1:0]))
    else $error("sweep write-back collides with read row");

  // A learning step on a valid state keeps the block busy
  a_step_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_STEP && in_range) |=> busy)
    else $error("accepted step did not start");

  // A result only follows an accepted transaction or work in progress
  a_done_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(start)))
    else $error("result without transaction");

endmodule
